@@ rtl/core/alcs_pkg.sv @@
package alcs_pkg;

  localparam int unsigned AddrW = 48;
  localparam int unsigned BeatW = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [BeatW-1:0] CONNECT_TIMEOUT_RST = 8'd2;
  localparam logic [BeatW-1:0] MEDIA_RUN_RST = 8'd10;

  localparam logic [CfgIdxW-1:0] REG_CONNECT_TIMEOUT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_MEDIA_RUN = 2'd1;

  localparam logic [2:0] OP_DISC_RESULT = 3'd0;
  localparam logic [2:0] OP_DISC_STOPPED = 3'd1;
  localparam logic [2:0] OP_CONN_STATE = 3'd2;
  localparam logic [2:0] OP_AUDIO_STATE = 3'd3;
  localparam logic [2:0] OP_AUDIO_CFG = 3'd4;
  localparam logic [2:0] OP_MEDIA_ACK = 3'd5;
  localparam logic [2:0] OP_HEARTBEAT = 3'd6;

  localparam logic [2:0] LK_IDLE = 3'd0;
  localparam logic [2:0] LK_DISCOVERING = 3'd1;
  localparam logic [2:0] LK_DISCOVERED = 3'd2;
  localparam logic [2:0] LK_UNCONNECTED = 3'd3;
  localparam logic [2:0] LK_CONNECTING = 3'd4;
  localparam logic [2:0] LK_CONNECTED = 3'd5;
  localparam logic [2:0] LK_DISCONNECTING = 3'd6;

  localparam logic [1:0] MD_IDLE = 2'd0;
  localparam logic [1:0] MD_STARTING = 2'd1;
  localparam logic [1:0] MD_STARTED = 2'd2;
  localparam logic [1:0] MD_STOPPING = 2'd3;

  localparam logic [1:0] CS_DISCONNECTED = 2'd0;
  localparam logic [1:0] CS_CONNECTED = 2'd2;

  localparam logic [1:0] ACK_CHECK = 2'd0;
  localparam logic [1:0] ACK_START = 2'd1;
  localparam logic [1:0] ACK_STOP = 2'd2;

  localparam logic [3:0] CMD_CONNECT = 4'd0;
  localparam logic [3:0] CMD_DISCONNECT = 4'd1;
  localparam logic [3:0] CMD_DISC_START = 4'd2;
  localparam logic [3:0] CMD_DISC_CANCEL = 4'd3;
  localparam logic [3:0] CMD_CHECK = 4'd4;
  localparam logic [3:0] CMD_MSTART = 4'd5;
  localparam logic [3:0] CMD_MSTOP = 4'd6;
  localparam logic [3:0] CMD_SCAN_ON = 4'd7;
  localparam logic [3:0] CMD_SCAN_OFF = 4'd8;

  typedef struct packed {
    logic [2:0]       opcode;
    logic             device_matches;
    logic [AddrW-1:0] device_address;
    logic [1:0]       conn_state;
    logic [1:0]       ack_command;
    logic             ack_success;
  } in_item_t;

  typedef struct packed {
    logic [3:0]       command;
    logic [AddrW-1:0] peer_address;
    logic [2:0]       link_now;
    logic [1:0]       media_now;
    logic             led_on;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic [2:0]       link;
    logic [1:0]       media;
    logic [BeatW-1:0] connect_beats;
    logic [BeatW-1:0] media_beats;
    logic [AddrW-1:0] peer;
    logic             led;
  } seq_state_t;

  typedef struct packed {
    logic [BeatW-1:0] connect_timeout;
    logic [BeatW-1:0] media_run;
  } cfg_t;

endpackage

@@ rtl/core/alcs_step.sv @@
module alcs_step (
  input  alcs_pkg::in_item_t   item,
  input  alcs_pkg::seq_state_t cur,
  input  alcs_pkg::cfg_t       cfg,
  output alcs_pkg::seq_state_t nxt,
  output logic                 res_valid,
  output alcs_pkg::out_item_t  res
);
  import alcs_pkg::*;

  logic             in_sm;
  logic             emit;
  logic [3:0]       cmd;
  logic [BeatW:0]   cb_inc;
  logic [BeatW:0]   mb_inc;
  logic             ack_ok;

  assign in_sm = (cur.link >= LK_UNCONNECTED) && (cur.link <= LK_DISCONNECTING);
  assign cb_inc = {1'b0, cur.connect_beats} + {{BeatW{1'b0}}, 1'b1};
  assign mb_inc = {1'b0, cur.media_beats} + {{BeatW{1'b0}}, 1'b1};
  assign ack_ok = item.ack_success;

  always_comb begin
    nxt = cur;
    emit = 1'b0;
    cmd = CMD_CONNECT;
    if (item.opcode == OP_DISC_RESULT) begin
      if (item.device_matches) begin
        nxt.link = LK_DISCOVERED;
        nxt.peer = item.device_address;
        emit = 1'b1;
        cmd = CMD_DISC_CANCEL;
      end
    end else if (item.opcode == OP_DISC_STOPPED) begin
      emit = 1'b1;
      if (cur.link == LK_DISCOVERED) begin
        nxt.link = LK_CONNECTING;
        cmd = CMD_CONNECT;
      end else begin
        cmd = CMD_DISC_START;
      end
    end else if (item.opcode == OP_CONN_STATE && in_sm) begin
      if (cur.link == LK_CONNECTING) begin
        if (item.conn_state == CS_CONNECTED) begin
          nxt.link = LK_CONNECTED;
          nxt.media = MD_IDLE;
          nxt.led = 1'b1;
          emit = 1'b1;
          cmd = CMD_SCAN_OFF;
        end else if (item.conn_state == CS_DISCONNECTED) begin
          nxt.link = LK_UNCONNECTED;
        end
      end else if (cur.link == LK_CONNECTED) begin
        if (item.conn_state == CS_DISCONNECTED) begin
          nxt.link = LK_UNCONNECTED;
          nxt.led = 1'b0;
          emit = 1'b1;
          cmd = CMD_SCAN_ON;
        end
      end else if (cur.link == LK_DISCONNECTING) begin
        if (item.conn_state == CS_DISCONNECTED) begin
          nxt.link = LK_UNCONNECTED;
          emit = 1'b1;
          cmd = CMD_SCAN_ON;
        end
      end
    end else if (item.opcode == OP_MEDIA_ACK && in_sm) begin
      if (cur.link == LK_CONNECTED) begin
        unique case (cur.media)
          MD_IDLE: begin
            if (item.ack_command == ACK_CHECK && ack_ok) begin
              emit = 1'b1;
              cmd = CMD_MSTART;
              nxt.media = MD_STARTING;
            end
          end
          MD_STARTING: begin
            if (item.ack_command == ACK_START && ack_ok) begin
              nxt.media_beats = '0;
              nxt.media = MD_STARTED;
            end else begin
              nxt.media = MD_IDLE;
            end
          end
          MD_STARTED: begin
          end
          default: begin
            emit = 1'b1;
            if (item.ack_command == ACK_STOP && ack_ok) begin
              nxt.media = MD_IDLE;
              nxt.link = LK_DISCONNECTING;
              cmd = CMD_DISCONNECT;
            end else begin
              cmd = CMD_MSTOP;
            end
          end
        endcase
      end
    end else if (item.opcode == OP_HEARTBEAT && in_sm) begin
      if (cur.link == LK_UNCONNECTED) begin
        emit = 1'b1;
        cmd = CMD_CONNECT;
        nxt.link = LK_CONNECTING;
        nxt.connect_beats = '0;
      end else if (cur.link == LK_CONNECTING) begin
        if (cb_inc >= {1'b0, cfg.connect_timeout}) begin
          nxt.link = LK_UNCONNECTED;
          nxt.connect_beats = '0;
        end else begin
          nxt.connect_beats = cb_inc[BeatW-1:0];
        end
      end else if (cur.link == LK_CONNECTED) begin
        if (cur.media == MD_IDLE) begin
          emit = 1'b1;
          cmd = CMD_CHECK;
        end else if (cur.media == MD_STARTED) begin
          if (mb_inc >= {1'b0, cfg.media_run}) begin
            emit = 1'b1;
            cmd = CMD_MSTOP;
            nxt.media = MD_STOPPING;
            nxt.media_beats = '0;
          end else begin
            nxt.media_beats = mb_inc[BeatW-1:0];
          end
        end
      end
    end
  end

  always_comb begin
    res_valid = emit;
    res.command = cmd;
    res.peer_address = (cmd == CMD_CONNECT || cmd == CMD_DISCONNECT) ? nxt.peer : '0;
    res.link_now = nxt.link;
    res.media_now = nxt.media;
    res.led_on = nxt.led;
    res.last = 1'b1;
  end

endmodule

@@ rtl/core/audio_link_connection_sequencer_unit.sv @@
// channel | dir | handshake            | payload
// in      | in  | in_valid / in_ready   | in_data  (alcs_pkg::in_item_t)
// out     | out | out_valid / out_ready | out_data (alcs_pkg::out_item_t)
// cfg     | in  | cfg_we               | cfg_index, cfg_wdata
//
// One transaction per cycle sustained while out_ready holds; out_valid rises once an accepted event
// has passed the input register, then the step logic into the result register.
// At most one result per event; events with no command leave no result.
// Reset (synchronous, rst_n low): link discovering, media idle, counters, peer and LED
// cleared, registers at their defaults. Both stages hold while a result waits on out_ready.
module audio_link_connection_sequencer_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  alcs_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output alcs_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [alcs_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [alcs_pkg::BeatW-1:0]       cfg_wdata
);
  import alcs_pkg::*;

  cfg_t       cfg_r;
  seq_state_t state_r;
  seq_state_t state_nxt;
  in_item_t   s1_item_r;
  logic       s1_valid_r;
  logic       out_valid_r;
  out_item_t  out_data_r;
  logic       res_valid;
  out_item_t  res;
  logic       out_free;
  logic       s1_go;

  assign out_free = !out_valid_r || out_ready;
  assign s1_go = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  alcs_step u_step (
    .item      (s1_item_r),
    .cur       (state_r),
    .cfg       (cfg_r),
    .nxt       (state_nxt),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.connect_timeout <= CONNECT_TIMEOUT_RST;
      cfg_r.media_run <= MEDIA_RUN_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_CONNECT_TIMEOUT) begin
        cfg_r.connect_timeout <= cfg_wdata;
      end else if (cfg_index == REG_MEDIA_RUN) begin
        cfg_r.media_run <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.link <= LK_DISCOVERING;
      state_r.media <= MD_IDLE;
      state_r.connect_beats <= '0;
      state_r.media_beats <= '0;
      state_r.peer <= '0;
      state_r.led <= 1'b0;
    end else if (s1_go) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_go && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res_valid) begin
      out_data_r <= res;
    end
  end

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r && $stable(s1_item_r))
    else $error("stalled event lost from input stage");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_go |=> $stable(state_r))
    else $error("state changed without an event");

  a_peer_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.command != CMD_CONNECT && out_data_r.command != CMD_DISCONNECT
    |-> out_data_r.peer_address == '0)
    else $error("peer address on a command that carries none");

endmodule

@@ tb/sv/tb.sv @@
module tb;
  import alcs_pkg::*;

  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam logic [1:0] CS_CONNECTING = 2'd1;
  localparam logic [1:0] CS_DISCONNECTING = 2'd3;
  localparam logic [1:0] ACK_OTHER = 2'd3;
  localparam logic [AddrW-1:0] ADDR_ONES = '1;
  localparam int PHASES = 5;
  localparam int PHASE_ITEMS = 200;
  localparam int HOLD_CYCLES = 60;

  typedef enum logic [1:0] {CHK_MODEL, CHK_TYPED, CHK_NONE} row_check_t;

  typedef struct {
    in_item_t   ev;
    row_check_t chk;
    out_item_t  want;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CfgIdxW-1:0]   cfg_index;
  logic [BeatW-1:0]     cfg_wdata;

  // shadow of the sequencer state and its registers
  logic [2:0]       p_link = LK_DISCOVERING;
  logic [1:0]       p_media = MD_IDLE;
  logic [BeatW-1:0] p_conn_cnt = '0;
  logic [BeatW-1:0] p_run_cnt = '0;
  logic [AddrW-1:0] p_peer = '0;
  logic             p_led = 1'b0;
  logic [BeatW-1:0] p_timeout = CONNECT_TIMEOUT_RST;
  logic [BeatW-1:0] p_run_len = MEDIA_RUN_RST;

  out_item_t pending_cmds[$];
  dir_row_t  dir_rows[$];
  int        mismatch_count = 0;
  bit        calm = 1'b0;
  bit        hold_req = 1'b0;

  logic [BeatW-1:0] timeout_set [PHASES] = '{8'd0, 8'd1, 8'd255, 8'd7, 8'd2};
  logic [BeatW-1:0] run_set [PHASES] = '{8'd0, 8'd255, 8'd1, 8'd5, 8'd10};

  audio_link_connection_sequencer_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic in_item_t evt(logic [2:0] op, logic m, logic [AddrW-1:0] a,
                                   logic [1:0] cs, logic [1:0] ak, logic ok);
    in_item_t ev;
    ev.opcode = op;
    ev.device_matches = m;
    ev.device_address = a;
    ev.conn_state = cs;
    ev.ack_command = ak;
    ev.ack_success = ok;
    return ev;
  endfunction

  function automatic out_item_t cmd_res(logic [3:0] cmd, logic [AddrW-1:0] peer,
                                       logic [2:0] link, logic [1:0] media, logic led);
    out_item_t r;
    r.command = cmd;
    r.peer_address = peer;
    r.link_now = link;
    r.media_now = media;
    r.led_on = led;
    r.last = 1'b1;
    return r;
  endfunction

  function automatic bit media_advance(input bit beat, input logic [1:0] ack, input logic ok,
                                       output logic [3:0] cmd);
    bit fired;
    logic [BeatW:0] nxt;
    fired = 1'b0;
    cmd = CMD_CHECK;
    case (p_media)
      MD_IDLE: begin
        if (beat) begin
          cmd = CMD_CHECK;
          fired = 1'b1;
        end else if (ack == ACK_CHECK && ok) begin
          cmd = CMD_MSTART;
          p_media = MD_STARTING;
          fired = 1'b1;
        end
      end
      MD_STARTING: begin
        if (!beat) begin
          if (ack == ACK_START && ok) begin
            p_run_cnt = '0;
            p_media = MD_STARTED;
          end else begin
            p_media = MD_IDLE;
          end
        end
      end
      MD_STARTED: begin
        if (beat) begin
          nxt = {1'b0, p_run_cnt} + 1'b1;
          if (nxt >= {1'b0, p_run_len}) begin
            cmd = CMD_MSTOP;
            p_media = MD_STOPPING;
            nxt = '0;
            fired = 1'b1;
          end
          p_run_cnt = nxt[BeatW-1:0];
        end
      end
      default: begin
        if (!beat) begin
          fired = 1'b1;
          if (ack == ACK_STOP && ok) begin
            p_media = MD_IDLE;
            cmd = CMD_DISCONNECT;
            p_link = LK_DISCONNECTING;
          end else begin
            cmd = CMD_MSTOP;
          end
        end
      end
    endcase
    return fired;
  endfunction

  function automatic bit predict_command(input in_item_t ev, output out_item_t res);
    bit fired;
    bit in_sm;
    logic [3:0] cmd;
    logic [BeatW:0] nxt;
    fired = 1'b0;
    cmd = CMD_CONNECT;
    in_sm = (p_link >= LK_UNCONNECTED) && (p_link <= LK_DISCONNECTING);
    case (ev.opcode)
      OP_DISC_RESULT: begin
        if (ev.device_matches) begin
          p_link = LK_DISCOVERED;
          p_peer = ev.device_address;
          cmd = CMD_DISC_CANCEL;
          fired = 1'b1;
        end
      end
      OP_DISC_STOPPED: begin
        fired = 1'b1;
        if (p_link == LK_DISCOVERED) begin
          p_link = LK_CONNECTING;
          cmd = CMD_CONNECT;
        end else begin
          cmd = CMD_DISC_START;
        end
      end
      OP_CONN_STATE: begin
        if (in_sm) begin
          if (p_link == LK_CONNECTING) begin
            if (ev.conn_state == CS_CONNECTED) begin
              p_link = LK_CONNECTED;
              p_media = MD_IDLE;
              p_led = 1'b1;
              cmd = CMD_SCAN_OFF;
              fired = 1'b1;
            end else if (ev.conn_state == CS_DISCONNECTED) begin
              p_link = LK_UNCONNECTED;
            end
          end else if (p_link == LK_CONNECTED) begin
            if (ev.conn_state == CS_DISCONNECTED) begin
              p_link = LK_UNCONNECTED;
              p_led = 1'b0;
              cmd = CMD_SCAN_ON;
              fired = 1'b1;
            end
          end else if (p_link == LK_DISCONNECTING) begin
            if (ev.conn_state == CS_DISCONNECTED) begin
              p_link = LK_UNCONNECTED;
              cmd = CMD_SCAN_ON;
              fired = 1'b1;
            end
          end
        end
      end
      OP_MEDIA_ACK: begin
        if (in_sm && p_link == LK_CONNECTED)
          fired = media_advance(1'b0, ev.ack_command, ev.ack_success, cmd);
      end
      OP_HEARTBEAT: begin
        if (in_sm) begin
          if (p_link == LK_UNCONNECTED) begin
            cmd = CMD_CONNECT;
            p_link = LK_CONNECTING;
            p_conn_cnt = '0;
            fired = 1'b1;
          end else if (p_link == LK_CONNECTING) begin
            nxt = {1'b0, p_conn_cnt} + 1'b1;
            if (nxt >= {1'b0, p_timeout}) begin
              p_link = LK_UNCONNECTED;
              nxt = '0;
            end
            p_conn_cnt = nxt[BeatW-1:0];
          end else if (p_link == LK_CONNECTED) begin
            fired = media_advance(1'b1, ACK_CHECK, 1'b0, cmd);
          end
        end
      end
      default: ;
    endcase
    res = cmd_res(cmd, (cmd == CMD_CONNECT || cmd == CMD_DISCONNECT) ? p_peer : '0,
                  p_link, p_media, p_led);
    return fired;
  endfunction

  // mostly legal link traffic with random content, some pure noise
  function automatic in_item_t make_event();
    in_item_t ev;
    int unsigned r;
    ev.opcode = 3'($urandom_range(0, 7));
    ev.device_matches = 1'($urandom);
    ev.device_address = {16'($urandom), 32'($urandom)};
    ev.conn_state = 2'($urandom);
    ev.ack_command = 2'($urandom);
    ev.ack_success = 1'($urandom);
    if ($urandom_range(0, 99) < 15) return ev;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      ev.opcode = OP_DISC_RESULT;
      ev.device_matches = 1'b1;
    end else begin
      case (p_link)
        LK_IDLE, LK_DISCOVERING: begin
          ev.opcode = (r < 60) ? OP_DISC_RESULT : OP_DISC_STOPPED;
          ev.device_matches = (r < 50);
        end
        LK_DISCOVERED: ev.opcode = OP_DISC_STOPPED;
        LK_UNCONNECTED: ev.opcode = OP_HEARTBEAT;
        LK_CONNECTING: begin
          if (r < 55) begin
            ev.opcode = OP_CONN_STATE;
            ev.conn_state = CS_CONNECTED;
          end else if (r < 85) begin
            ev.opcode = OP_HEARTBEAT;
          end else if (r < 93) begin
            ev.opcode = OP_CONN_STATE;
            ev.conn_state = CS_DISCONNECTED;
          end else begin
            ev.opcode = OP_DISC_STOPPED;
          end
        end
        LK_DISCONNECTING: begin
          ev.opcode = OP_CONN_STATE;
          if (r < 80) ev.conn_state = CS_DISCONNECTED;
        end
        default: begin
          case (p_media)
            MD_IDLE: begin
              if (r < 45) begin
                ev.opcode = OP_HEARTBEAT;
              end else begin
                ev.opcode = OP_MEDIA_ACK;
                ev.ack_command = ACK_CHECK;
                ev.ack_success = (r < 92);
              end
            end
            MD_STARTING: begin
              ev.opcode = OP_MEDIA_ACK;
              if (r < 85) begin
                ev.ack_command = ACK_START;
                ev.ack_success = 1'b1;
              end
            end
            MD_STARTED: begin
              if (r < 93) begin
                ev.opcode = OP_HEARTBEAT;
              end else begin
                ev.opcode = OP_CONN_STATE;
                ev.conn_state = CS_DISCONNECTED;
              end
            end
            default: begin
              ev.opcode = OP_MEDIA_ACK;
              if (r < 75) begin
                ev.ack_command = ACK_STOP;
                ev.ack_success = 1'b1;
              end
            end
          endcase
        end
      endcase
    end
    return ev;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input logic [AddrW-1:0] got,
                             input logic [AddrW-1:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic add_row(input in_item_t ev, input row_check_t chk, input out_item_t want);
    dir_row_t row;
    row.ev = ev;
    row.chk = chk;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  task automatic send_event(input in_item_t ev, input row_check_t chk, input out_item_t want);
    out_item_t res;
    bit fired;
    in_valid <= 1'b1;
    in_data <= ev;
    do @(posedge clk); while (!in_ready);
    fired = predict_command(ev, res);
    if (chk == CHK_TYPED) pending_cmds.push_back(want);
    else if (chk == CHK_MODEL && fired) pending_cmds.push_back(res);
  endtask

  task automatic sender_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_regs(input logic [BeatW-1:0] timeout, input logic [BeatW-1:0] run);
    cfg_we <= 1'b1;
    cfg_index <= REG_CONNECT_TIMEOUT;
    cfg_wdata <= timeout;
    @(posedge clk);
    cfg_index <= REG_MEDIA_RUN;
    cfg_wdata <= run;
    @(posedge clk);
    // unmapped index, must be ignored
    cfg_index <= 2'($urandom_range(2, 3));
    cfg_wdata <= 8'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    p_timeout = timeout;
    p_run_len = run;
  endtask

  // receiver pacing: short random stalls, one long hold-off on request
  initial begin : rx_pacing
    int unsigned n;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_cmds.size() == 0) begin
        report_mismatch($sformatf("unexpected command %0d", out_data.command));
      end else begin
        want = pending_cmds.pop_front();
        check_field("command", AddrW'(out_data.command), AddrW'(want.command));
        check_field("peer_address", out_data.peer_address, want.peer_address);
        check_field("link_now", AddrW'(out_data.link_now), AddrW'(want.link_now));
        check_field("media_now", AddrW'(out_data.media_now), AddrW'(want.media_now));
        check_field("led_on", AddrW'(out_data.led_on), AddrW'(want.led_on));
        check_field("last", AddrW'(out_data.last), AddrW'(want.last));
      end
    end
  end

  initial begin
    #3000000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    int ph;
    int k;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;

    // directed walk, run length set to 1 below
    add_row(evt(OP_UNUSED, 1'b1, ADDR_ONES, CS_DISCONNECTING, ACK_OTHER, 1'b1), CHK_NONE, '0);
    add_row(evt(OP_AUDIO_STATE, 1'b1, ADDR_ONES, CS_DISCONNECTING, ACK_OTHER, 1'b1),
            CHK_NONE, '0);
    add_row(evt(OP_AUDIO_CFG, 1'b1, ADDR_ONES, CS_DISCONNECTING, ACK_OTHER, 1'b1),
            CHK_NONE, '0);
    add_row(evt(OP_HEARTBEAT, 1'b0, '0, '0, '0, 1'b0), CHK_NONE, '0);
    add_row(evt(OP_MEDIA_ACK, 1'b0, '0, '0, ACK_CHECK, 1'b1), CHK_NONE, '0);
    add_row(evt(OP_DISC_RESULT, 1'b0, ADDR_ONES, '0, '0, 1'b0), CHK_NONE, '0);
    add_row(evt(OP_DISC_STOPPED, 1'b0, '0, '0, '0, 1'b0), CHK_TYPED,
            cmd_res(CMD_DISC_START, '0, LK_DISCOVERING, MD_IDLE, 1'b0));
    add_row(evt(OP_DISC_RESULT, 1'b1, '0, '0, '0, 1'b0), CHK_TYPED,
            cmd_res(CMD_DISC_CANCEL, '0, LK_DISCOVERED, MD_IDLE, 1'b0));
    add_row(evt(OP_DISC_RESULT, 1'b1, ADDR_ONES, '0, '0, 1'b0), CHK_TYPED,
            cmd_res(CMD_DISC_CANCEL, '0, LK_DISCOVERED, MD_IDLE, 1'b0));
    add_row(evt(OP_DISC_STOPPED, 1'b0, '0, '0, '0, 1'b0), CHK_TYPED,
            cmd_res(CMD_CONNECT, ADDR_ONES, LK_CONNECTING, MD_IDLE, 1'b0));
    add_row(evt(OP_CONN_STATE, 1'b0, '0, CS_DISCONNECTING, '0, 1'b0), CHK_NONE, '0);
    add_row(evt(OP_HEARTBEAT, 1'b0, '0, '0, '0, 1'b0), CHK_NONE, '0);
    add_row(evt(OP_HEARTBEAT, 1'b0, '0, '0, '0, 1'b0), CHK_NONE, '0);
    add_row(evt(OP_HEARTBEAT, 1'b0, '0, '0, '0, 1'b0), CHK_TYPED,
            cmd_res(CMD_CONNECT, ADDR_ONES, LK_CONNECTING, MD_IDLE, 1'b0));
    add_row(evt(OP_CONN_STATE, 1'b0, '0, CS_CONNECTING, '0, 1'b0), CHK_NONE, '0);
    add_row(evt(OP_CONN_STATE, 1'b0, '0, CS_DISCONNECTED, '0, 1'b0), CHK_NONE, '0);
    add_row(evt(OP_HEARTBEAT, 1'b0, '0, '0, '0, 1'b0), CHK_MODEL, '0);
    add_row(evt(OP_CONN_STATE, 1'b0, '0, CS_CONNECTED, '0, 1'b0), CHK_TYPED,
            cmd_res(CMD_SCAN_OFF, '0, LK_CONNECTED, MD_IDLE, 1'b1));
    add_row(evt(OP_HEARTBEAT, 1'b0, '0, '0, '0, 1'b0), CHK_TYPED,
            cmd_res(CMD_CHECK, '0, LK_CONNECTED, MD_IDLE, 1'b1));
    add_row(evt(OP_MEDIA_ACK, 1'b0, '0, '0, ACK_CHECK, 1'b1), CHK_TYPED,
            cmd_res(CMD_MSTART, '0, LK_CONNECTED, MD_STARTING, 1'b1));
    add_row(evt(OP_MEDIA_ACK, 1'b0, '0, '0, ACK_START, 1'b0), CHK_NONE, '0);
    add_row(evt(OP_MEDIA_ACK, 1'b0, '0, '0, ACK_CHECK, 1'b1), CHK_MODEL, '0);
    add_row(evt(OP_MEDIA_ACK, 1'b0, '0, '0, ACK_START, 1'b1), CHK_NONE, '0);
    add_row(evt(OP_HEARTBEAT, 1'b0, '0, '0, '0, 1'b0), CHK_TYPED,
            cmd_res(CMD_MSTOP, '0, LK_CONNECTED, MD_STOPPING, 1'b1));
    add_row(evt(OP_MEDIA_ACK, 1'b0, '0, '0, ACK_OTHER, 1'b1), CHK_TYPED,
            cmd_res(CMD_MSTOP, '0, LK_CONNECTED, MD_STOPPING, 1'b1));
    add_row(evt(OP_MEDIA_ACK, 1'b0, '0, '0, ACK_STOP, 1'b1), CHK_TYPED,
            cmd_res(CMD_DISCONNECT, ADDR_ONES, LK_DISCONNECTING, MD_IDLE, 1'b1));
    add_row(evt(OP_CONN_STATE, 1'b0, '0, CS_DISCONNECTED, '0, 1'b0), CHK_MODEL, '0);
    add_row(evt(OP_HEARTBEAT, 1'b0, '0, '0, '0, 1'b0), CHK_MODEL, '0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    write_regs(CONNECT_TIMEOUT_RST, 8'd1);

    foreach (dir_rows[i]) begin
      send_event(dir_rows[i].ev, dir_rows[i].chk, dir_rows[i].want);
      sender_gap();
    end

    // long receiver hold-off while discovery-stopped events keep coming
    hold_req = 1'b1;
    for (k = 0; k < 12; k++) begin
      send_event(evt(OP_DISC_STOPPED, 1'($urandom), {16'($urandom), 32'($urandom)},
                     2'($urandom), 2'($urandom), 1'($urandom)), CHK_MODEL, '0);
    end
    drain();

    for (ph = 0; ph < PHASES; ph++) begin
      write_regs(timeout_set[ph], run_set[ph]);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == PHASES - 1 && k >= PHASE_ITEMS / 2) calm = 1'b1;
        send_event(make_event(), CHK_MODEL, '0);
        sender_gap();
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
